### rtl/rpv_pkg.sv
// Shared types and constants for the relative path validator.
// Used by rpv_front, rpv_back and relative_path_validator; no dependencies.
package rpv_pkg;

	localparam int MAX_FIELD_DEF = 1024;
	localparam int BYTE_W = 8;
	localparam int FS_W = 11;
	localparam logic [FS_W-1:0] FS_RESET = 11'd256;
	localparam int STATUS_W = 3;

	// Queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result queue at the output.
	localparam int OUT_DEPTH = 2;
	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_ABSOLUTE = 3'd3,
		ST_UNPRINTABLE = 3'd4,
		ST_COLON = 3'd5,
		ST_EMPTY_SEG = 3'd6,
		ST_DOT_SEG = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		CF_NONE = 2'd0,
		CF_UNPRINTABLE = 2'd1,
		CF_COLON = 2'd2
	} char_fault_t;

	typedef enum logic [1:0] {
		SF_NONE = 2'd0,
		SF_EMPTY = 2'd1,
		SF_DOT = 2'd2
	} seg_fault_t;

	// Class of one path byte, as decided by the front part.
	typedef struct packed {
		logic term;
		logic slash;
		logic dot;
		logic unprint;
		logic colon;
	} byte_class_t;

	// Head of the class queue as seen by the back part.
	typedef struct packed {
		logic        valid;
		byte_class_t cls;
	} class_head_t;

endpackage

### rtl/rpv_front.sv
// Front part: accepts path bytes, classifies them and queues the classes.
// Depends on rpv_pkg.
module rpv_front
	import rpv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] path_byte,
	output class_head_t       head,
	input  logic              head_pop
);

	byte_class_t              mem_q [QDEPTH];
	logic        [QPTR_W-1:0] wptr_q;
	logic        [QPTR_W-1:0] rptr_q;
	logic        [QCNT_W-1:0] cnt_q;
	byte_class_t              cls;
	logic                     wr;
	logic                     rd;

	always_comb begin
		cls.term = (path_byte == CH_NUL);
		cls.slash = (path_byte == CH_SLASH);
		cls.dot = (path_byte == CH_DOT);
		cls.unprint = (path_byte < CH_PRINT_LO) || (path_byte > CH_PRINT_HI);
		cls.colon = (path_byte == CH_COLON);
	end

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign wr = push && !full;
	assign rd = head_pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.cls = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("class queue count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full && !head_pop) |=> $stable(cnt_q))
		else $error("class queue changed while full and not read");

endmodule

### rtl/rpv_back.sv
// Back part: updates the path state per byte class, forms the status on the
// terminator and holds results in a small output queue. Depends on rpv_pkg.
module rpv_back
	import rpv_pkg::*;
#(
	parameter int MAX_FIELD = MAX_FIELD_DEF,
	parameter int LEN_W = $clog2(MAX_FIELD + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [FS_W-1:0]     cfg_wr_data,
	input  class_head_t         head,
	output logic                head_pop,
	output logic                empty,
	input  logic                pop,
	output logic [STATUS_W-1:0] status,
	output logic [LEN_W-1:0]    path_length
);

	localparam int CMP_W = (LEN_W > FS_W) ? LEN_W : FS_W;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FIELD);

	logic        [FS_W-1:0]  fsize_q;
	logic        [LEN_W-1:0] len_q, len_n;
	logic                    slash_q, slash_n;
	char_fault_t             cf_q, cf_n;
	seg_fault_t              sf_q, sf_n;
	logic        [1:0]       seg_len_q, seg_len_n;
	logic                    dot1_q, dot1_n;
	logic                    dot2_q, dot2_n;
	seg_fault_t              sf_close;
	status_t                 st;
	logic                    take;
	logic                    out_wr;
	logic                    out_rd;

	status_t                 out_st_q [OUT_DEPTH];
	logic        [LEN_W-1:0] out_len_q [OUT_DEPTH];
	logic        [OPTR_W-1:0] out_wptr_q;
	logic        [OPTR_W-1:0] out_rptr_q;
	logic        [OCNT_W-1:0] out_cnt_q;

	// A terminator needs room in the output queue; other bytes never wait.
	assign take = head.valid && (!head.cls.term || (out_cnt_q != OCNT_W'(OUT_DEPTH)));
	assign head_pop = take;
	assign out_wr = take && head.cls.term;
	assign out_rd = pop && !empty;

	// Fault that closing the current segment would record.
	always_comb begin
		sf_close = sf_q;
		if (sf_q == SF_NONE) begin
			if (seg_len_q == 2'd0) begin
				sf_close = SF_EMPTY;
			end else if (dot1_q && ((seg_len_q == 2'd1) || ((seg_len_q == 2'd2) && dot2_q))) begin
				sf_close = SF_DOT;
			end
		end
	end

	// Status ranking on the terminator.
	always_comb begin
		if (len_q == '0) begin
			st = ST_EMPTY;
		end else if ((CMP_W'(len_q) >= CMP_W'(fsize_q)) || (len_q == LEN_MAX)) begin
			st = ST_TOO_LONG;
		end else if (slash_q) begin
			st = ST_ABSOLUTE;
		end else if (cf_q == CF_UNPRINTABLE) begin
			st = ST_UNPRINTABLE;
		end else if (cf_q == CF_COLON) begin
			st = ST_COLON;
		end else if (sf_close == SF_EMPTY) begin
			st = ST_EMPTY_SEG;
		end else if (sf_close == SF_DOT) begin
			st = ST_DOT_SEG;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		len_n = len_q;
		slash_n = slash_q;
		cf_n = cf_q;
		sf_n = sf_q;
		seg_len_n = seg_len_q;
		dot1_n = dot1_q;
		dot2_n = dot2_q;
		if (take) begin
			if (head.cls.term) begin
				len_n = '0;
				slash_n = 1'b0;
				cf_n = CF_NONE;
				sf_n = SF_NONE;
				seg_len_n = 2'd0;
				dot1_n = 1'b0;
				dot2_n = 1'b0;
			end else begin
				if ((len_q == '0) && head.cls.slash) begin
					slash_n = 1'b1;
				end
				if (len_q != LEN_MAX) begin
					len_n = len_q + 1'b1;
				end
				if (cf_q == CF_NONE) begin
					if (head.cls.unprint) begin
						cf_n = CF_UNPRINTABLE;
					end else if (head.cls.colon) begin
						cf_n = CF_COLON;
					end
				end
				if (head.cls.slash) begin
					sf_n = sf_close;
					seg_len_n = 2'd0;
					dot1_n = 1'b0;
					dot2_n = 1'b0;
				end else begin
					if (head.cls.dot) begin
						if (seg_len_q == 2'd0) begin
							dot1_n = 1'b1;
						end else if (seg_len_q == 2'd1) begin
							dot2_n = 1'b1;
						end
					end
					if (seg_len_q != 2'd3) begin
						seg_len_n = seg_len_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize_q <= FS_RESET;
			len_q <= '0;
			slash_q <= 1'b0;
			cf_q <= CF_NONE;
			sf_q <= SF_NONE;
			seg_len_q <= 2'd0;
			dot1_q <= 1'b0;
			dot2_q <= 1'b0;
			out_wptr_q <= '0;
			out_rptr_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				fsize_q <= cfg_wr_data;
			end
			len_q <= len_n;
			slash_q <= slash_n;
			cf_q <= cf_n;
			sf_q <= sf_n;
			seg_len_q <= seg_len_n;
			dot1_q <= dot1_n;
			dot2_q <= dot2_n;
			if (out_wr) begin
				out_wptr_q <= out_wptr_q + 1'b1;
			end
			if (out_rd) begin
				out_rptr_q <= out_rptr_q + 1'b1;
			end
			if (out_wr && !out_rd) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (out_rd && !out_wr) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_st_q[out_wptr_q] <= st;
			out_len_q[out_wptr_q] <= len_q;
		end
	end

	assign empty = (out_cnt_q == '0);
	assign status = out_st_q[out_rptr_q];
	assign path_length = out_len_q[out_rptr_q];

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= OCNT_W'(OUT_DEPTH))
		else $error("output queue count above depth");

	a_term_queues: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.cls.term && !out_rd) |=> (out_cnt_q == $past(out_cnt_q) + 1'b1))
		else $error("terminator taken without queuing a result");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.cls.term) |=> ((len_q == '0) && (seg_len_q == 2'd0) && !slash_q))
		else $error("path state not cleared after terminator");

endmodule

### rtl/relative_path_validator.sv
// Relative path validator top level: front classifier, class queue and back
// state machine. Depends on rpv_pkg, rpv_front and rpv_back.
//
// Path bytes enter through push/full, one word per cycle while full is low; a zero
// byte ends the path and produces one result word (status and length) on the
// empty/pop side. The back part updates its state for every byte, so the block
// sustains one byte per clock unless a terminator waits for room in the result
// queue. A four-entry class queue and a two-entry result queue decouple the
// sides; when results are not popped, the result queue fills, the back part
// holds at the next terminator, and full rises once the class queue has filled
// behind it. The field size register may be written only while idle.
module relative_path_validator
	import rpv_pkg::*;
#(
	parameter int MAX_FIELD = MAX_FIELD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [BYTE_W-1:0]             path_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [STATUS_W-1:0]           status,
	output logic [$clog2(MAX_FIELD+1)-1:0] path_length,
	input  logic                          cfg_wr_en,
	input  logic [FS_W-1:0]               cfg_wr_data
);

	localparam int LEN_W = $clog2(MAX_FIELD + 1);

	class_head_t head;
	logic        head_pop;

	rpv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.path_byte(path_byte),
		.head     (head),
		.head_pop (head_pop)
	);

	rpv_back #(
		.MAX_FIELD(MAX_FIELD),
		.LEN_W    (LEN_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.path_length(path_length)
	);

endmodule

### verif/relative_path_validator_tb.sv
// Self-checking testbench for relative_path_validator: directed path table, then random
// paths over several field sizes, with bursty push and patterned pop stalls.
// Depends on rpv_pkg and the relative_path_validator RTL.
`timescale 1ns / 1ps

module relative_path_validator_tb;
	import rpv_pkg::*;

	localparam int LEN_W = $clog2(MAX_FIELD_DEF + 1);
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_BYTES = 800;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		status_t          st;
		logic [LEN_W-1:0] len;
	} path_result_t;

	typedef struct packed {
		logic             set_cfg;
		logic [FS_W-1:0]  fs;
		logic [10:0]      fill;
		logic [3:0]       n;
		logic [63:0]      chars;
		logic             known;
		status_t          st;
		logic [LEN_W-1:0] len;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [BYTE_W-1:0]   path_byte = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    path_length;
	logic                cfg_wr_en = 1'b0;
	logic [FS_W-1:0]     cfg_wr_data = '0;

	relative_path_validator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.path_byte  (path_byte),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.path_length(path_length),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Shadow of the block's path state and its field size register.
	logic [FS_W-1:0]  shadow_fs = FS_RESET;
	logic [LEN_W-1:0] byte_count = '0;
	logic             lead_slash = 1'b0;
	char_fault_t      char_flt = CF_NONE;
	seg_fault_t       seg_flt = SF_NONE;
	logic [1:0]       seg_len = '0;
	logic             seg_dot0 = 1'b0;
	logic             seg_dot1 = 1'b0;

	path_result_t results_due[$];
	dir_row_t     dir_tab[$];
	logic [7:0]   pbuf[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int paths_sent = 0;
	int fs_writes = 0;
	int burst_left = 0;
	int rx_cyc = 0;
	int status_seen[8];

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void close_segment_shadow();
		if (seg_flt == SF_NONE) begin
			if (seg_len == 2'd0)
				seg_flt = SF_EMPTY;
			else if (seg_dot0 && (seg_len == 2'd1 || (seg_len == 2'd2 && seg_dot1)))
				seg_flt = SF_DOT;
		end
		seg_len = '0;
		seg_dot0 = 1'b0;
		seg_dot1 = 1'b0;
	endfunction

	// Advances the shadow state by one byte; returns 1 with the path verdict on a terminator.
	function automatic bit advance_path(input logic [7:0] b, output path_result_t r);
		logic [LEN_W-1:0] limit;
		r.st = ST_OK;
		r.len = '0;
		if (b != CH_NUL) begin
			if (byte_count == 0 && b == CH_SLASH)
				lead_slash = 1'b1;
			if (byte_count < MAX_FIELD_DEF)
				byte_count = byte_count + 1'b1;
			if (char_flt == CF_NONE) begin
				if (b < CH_PRINT_LO || b > CH_PRINT_HI)
					char_flt = CF_UNPRINTABLE;
				else if (b == CH_COLON)
					char_flt = CF_COLON;
			end
			if (b == CH_SLASH) begin
				close_segment_shadow();
			end else begin
				if (b == CH_DOT) begin
					if (seg_len == 2'd0)
						seg_dot0 = 1'b1;
					else if (seg_len == 2'd1)
						seg_dot1 = 1'b1;
				end
				if (seg_len < 2'd3)
					seg_len = seg_len + 1'b1;
			end
			return 1'b0;
		end
		limit = (shadow_fs > MAX_FIELD_DEF) ? LEN_W'(MAX_FIELD_DEF) : LEN_W'(shadow_fs);
		close_segment_shadow();
		if (byte_count == 0)
			r.st = ST_EMPTY;
		else if (byte_count >= limit)
			r.st = ST_TOO_LONG;
		else if (lead_slash)
			r.st = ST_ABSOLUTE;
		else if (char_flt == CF_UNPRINTABLE)
			r.st = ST_UNPRINTABLE;
		else if (char_flt == CF_COLON)
			r.st = ST_COLON;
		else if (seg_flt == SF_EMPTY)
			r.st = ST_EMPTY_SEG;
		else if (seg_flt == SF_DOT)
			r.st = ST_DOT_SEG;
		r.len = byte_count;
		byte_count = '0;
		lead_slash = 1'b0;
		char_flt = CF_NONE;
		seg_flt = SF_NONE;
		seg_len = '0;
		seg_dot0 = 1'b0;
		seg_dot1 = 1'b0;
		return 1'b1;
	endfunction

	function automatic dir_row_t mk(input logic set_cfg, input int fs, input int fill,
			input int n, input logic [63:0] chars, input logic known, input status_t st,
			input int len);
		dir_row_t row;
		row.set_cfg = set_cfg;
		row.fs = FS_W'(fs);
		row.fill = 11'(fill);
		row.n = 4'(n);
		row.chars = chars;
		row.known = known;
		row.st = st;
		row.len = LEN_W'(len);
		return row;
	endfunction

	function automatic logic [7:0] seg_char();
		logic [7:0] c;
		if ($urandom_range(0, 5) == 0)
			return CH_DOT;
		c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
		if (c == CH_SLASH || c == CH_COLON)
			c = "_";
		return c;
	endfunction

	task automatic wait_idle();
		push <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_fsize(input logic [FS_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_fs = value;
		fs_writes++;
	endtask

	// Sends one word; push stays high into the next word unless a gap is taken.
	task automatic send_byte(input logic [7:0] b, output bit got, output path_result_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		burst_left--;
		push <= 1'b1;
		path_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
		got = advance_path(b, r);
	endtask

	task automatic send_path(input bit known, input path_result_t typed);
		path_result_t r;
		bit got;
		foreach (pbuf[k])
			send_byte(pbuf[k], got, r);
		send_byte(CH_NUL, got, r);
		results_due.push_back(known ? typed : r);
		paths_sent++;
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Result side: checks every popped word and drives its own stall pattern.
	always @(posedge clk) begin
		path_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				status_seen[status]++;
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected word status=%0d length=%0d",
						status, path_length));
				end else begin
					want = results_due.pop_front();
					if (status !== want.st)
						report_mismatch($sformatf("status expected %0d got %0d (length %0d)",
							want.st, status, want.len));
					if (path_length !== want.len)
						report_mismatch($sformatf("length expected %0d got %0d",
							want.len, path_length));
				end
			end
			rx_cyc++;
			case ((rx_cyc / 256) % 4)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= ((rx_cyc % 32) >= 20);
				default: pop <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		path_result_t typed;
		int phase_bytes;
		int kind;
		int nseg;
		int slen;
		int idx;
		int total;
		int fs_plan[8];

		fs_plan = '{256, 0, 1, 2047, 24, 1024, 3, 0};
		fs_plan[7] = $urandom_range(4, 1023);

		// Directed paths. Rows with a typed verdict are checked against it directly.
		dir_tab.push_back(mk(0, 0, 0, 0, 0, 1, ST_EMPTY, 0));
		dir_tab.push_back(mk(0, 0, 0, 1, "a", 1, ST_OK, 1));
		dir_tab.push_back(mk(0, 0, 0, 2, "/a", 1, ST_ABSOLUTE, 2));
		dir_tab.push_back(mk(0, 0, 0, 1, "/", 1, ST_ABSOLUTE, 1));
		dir_tab.push_back(mk(0, 0, 0, 4, "a//b", 1, ST_EMPTY_SEG, 4));
		dir_tab.push_back(mk(0, 0, 0, 2, "a/", 1, ST_EMPTY_SEG, 2));
		dir_tab.push_back(mk(0, 0, 0, 1, ".", 1, ST_DOT_SEG, 1));
		dir_tab.push_back(mk(0, 0, 0, 4, "a/..", 1, ST_DOT_SEG, 4));
		dir_tab.push_back(mk(0, 0, 0, 3, "...", 0, ST_OK, 0));
		dir_tab.push_back(mk(0, 0, 0, 5, "./.a/", 0, ST_OK, 0));
		dir_tab.push_back(mk(0, 0, 0, 3, "a:b", 1, ST_COLON, 3));
		dir_tab.push_back(mk(0, 0, 0, 2, {8'h1F, "a"}, 1, ST_UNPRINTABLE, 2));
		dir_tab.push_back(mk(0, 0, 0, 2, {"a", 8'h7F}, 1, ST_UNPRINTABLE, 2));
		dir_tab.push_back(mk(0, 0, 0, 1, 8'hFF, 1, ST_UNPRINTABLE, 1));
		dir_tab.push_back(mk(0, 0, 0, 2, {8'h20, 8'h7E}, 1, ST_OK, 2));
		dir_tab.push_back(mk(0, 0, 0, 2, {":", 8'h01}, 1, ST_COLON, 2));
		dir_tab.push_back(mk(0, 0, 0, 2, "/:", 1, ST_ABSOLUTE, 2));
		dir_tab.push_back(mk(0, 0, 0, 6, {8'h80, "a:/./"}, 0, ST_OK, 0));
		dir_tab.push_back(mk(1, 1, 0, 1, "a", 1, ST_TOO_LONG, 1));
		dir_tab.push_back(mk(1, 2, 0, 1, "a", 1, ST_OK, 1));
		dir_tab.push_back(mk(0, 0, 0, 2, "ab", 1, ST_TOO_LONG, 2));
		dir_tab.push_back(mk(1, 0, 0, 0, 0, 1, ST_EMPTY, 0));
		dir_tab.push_back(mk(0, 0, 0, 1, "a", 1, ST_TOO_LONG, 1));
		// After saturation the character and segment checks must still settle cleanly.
		dir_tab.push_back(mk(1, 2047, 1030, 3, "/x/", 1, ST_TOO_LONG, 1024));
		dir_tab.push_back(mk(0, 0, 0, 3, "x/y", 1, ST_OK, 3));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].set_cfg)
				set_fsize(dir_tab[i].fs);
			pbuf.delete();
			repeat (dir_tab[i].fill) pbuf.push_back("b");
			for (int j = dir_tab[i].n - 1; j >= 0; j--)
				pbuf.push_back(dir_tab[i].chars[8*j +: 8]);
			typed.st = dir_tab[i].st;
			typed.len = dir_tab[i].len;
			send_path(dir_tab[i].known, typed);
		end

		// Random paths: mostly well-formed relative paths, mixed with damaged ones and noise.
		for (int ph = 0; ph < 8; ph++) begin
			set_fsize(FS_W'(fs_plan[ph]));
			phase_bytes = 0;
			while (phase_bytes < RANDOM_BYTES / 8) begin
				pbuf.delete();
				kind = $urandom_range(0, 99);
				if (kind < 5 && shadow_fs <= 64) begin
					total = (shadow_fs < 2) ? 1 : $urandom_range(shadow_fs - 1, shadow_fs + 1);
					repeat (total) pbuf.push_back(seg_char());
				end else if (kind < 15) begin
					repeat ($urandom_range(1, 10)) pbuf.push_back(8'($urandom_range(1, 255)));
				end else begin
					nseg = $urandom_range(1, 4);
					for (int s = 0; s < nseg; s++) begin
						if (s != 0)
							pbuf.push_back(CH_SLASH);
						slen = $urandom_range(1, 6);
						repeat (slen) pbuf.push_back(seg_char());
					end
					if (kind >= 65) begin
						idx = $urandom_range(0, pbuf.size());
						case ($urandom_range(0, 5))
							0: pbuf.push_front(CH_SLASH);
							1: pbuf.insert(idx, CH_SLASH);
							2: pbuf.push_back(CH_SLASH);
							3: pbuf.insert(idx, CH_COLON);
							4: pbuf.insert(idx, ($urandom_range(0, 1) != 0) ?
								8'($urandom_range(1, 8'h1F)) : 8'($urandom_range(8'h7F, 8'hFF)));
							default: begin
								pbuf.push_back(CH_SLASH);
								pbuf.push_back(CH_DOT);
								if ($urandom_range(0, 1) != 0)
									pbuf.push_back(CH_DOT);
							end
						endcase
					end
				end
				phase_bytes += pbuf.size() + 1;
				typed.st = ST_OK;
				typed.len = '0;
				send_path(1'b0, typed);
			end
		end

		wait_idle();
		$display("Sent %0d path bytes in %0d paths across %0d field size writes.",
			bytes_sent, paths_sent, fs_writes);
		$display("Verdicts ok/empty/long/abs/unprint/colon/emptyseg/dotseg: %s",
			$sformatf("%0d %0d %0d %0d %0d %0d %0d %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5], status_seen[6], status_seen[7]));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
